FILE: hdl/bap_pkg.sv
`timescale 1ns / 1ps
// Package for the bump arena handle allocator: sizes, request and status
// codes, slot table entry and write types. No dependencies.
package bap_pkg;

    // Arena and table sizing
    localparam int MAX_SLOTS   = 256;
    localparam int MAX_ALIGN   = 16;
    localparam int OFFSET_BITS = 20;
    localparam int SLOT_BITS   = $clog2(MAX_SLOTS);
    localparam int CNT_BITS    = SLOT_BITS + 1;
    localparam int CAP_BITS    = OFFSET_BITS + 1;
    localparam int EPOCH_BITS  = 32;

    localparam logic [CAP_BITS-1:0] CAP_LIMIT = CAP_BITS'(1) << OFFSET_BITS;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(65536);
    localparam logic [CNT_BITS-1:0] SLOTS_FULL = CNT_BITS'(MAX_SLOTS);

    // Register map, selected by paddr[2]
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_IDENTITY = 1'b1;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RESOLVE = 2'd1,
        REQ_ABANDON = 2'd2,
        REQ_RESET   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_ARG    = 3'd1,
        ST_NO_MEM     = 3'd2,
        ST_BAD_HANDLE = 3'd3,
        ST_STALE      = 3'd4
    } status_t;

    // One slot table entry; the generation low word is slot+1, so only
    // the epoch is kept.
    typedef struct packed {
        logic [OFFSET_BITS-1:0] offset;
        logic [CAP_BITS-1:0]    size;
        logic [EPOCH_BITS-1:0]  epoch;
        logic                   active;
    } slot_entry_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        slot_entry_t          data;
    } tbl_wr_t;

endpackage

FILE: hdl/bap_slot_tbl.sv
`timescale 1ns / 1ps
// Slot table memory for the bump arena allocator: one write port, one
// registered read port, with write-to-read forwarding. Depends on bap_pkg.
module bap_slot_tbl
(
    input  logic                          clk,
    input  logic [bap_pkg::SLOT_BITS-1:0] rd_addr,
    input  bap_pkg::tbl_wr_t              wr,
    output bap_pkg::slot_entry_t          rd_data
);
    import bap_pkg::*;

    slot_entry_t mem [MAX_SLOTS];
    slot_entry_t mem_rd_reg;
    slot_entry_t byp_data_reg;
    logic        byp_hit_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        mem_rd_reg <= mem[rd_addr];
    end

    // Forward a write landing on the same edge as the read
    always_ff @(posedge clk)
    begin
        byp_hit_reg  <= wr.en && (wr.addr == rd_addr);
        byp_data_reg <= wr.data;
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : mem_rd_reg;

endmodule

FILE: hdl/bump_arena_handle_allocator.sv
`timescale 1ns / 1ps
// Top level of the bump arena allocator with generational handles.
// Depends on bap_pkg and bap_slot_tbl.
//
//  Channel   | Handshake                      | Contents
//  ----------+--------------------------------+--------------------------------
//  request   | start && !busy                 | req_type, alloc_size, align,
//            |                                | handle slot/generation/arena
//  result    | done strobe, one cycle         | status, region, new handle,
//            |                                | cursor, live slots, epoch
//  config    | APB, psel&penable&pwrite       | arena_capacity, arena_identity
//
// One transaction per cycle; busy is always low. The done strobe rises once
// its request has passed the input register, loaded as the request is taken
// while the slot table is read, and then the result register.
// Reset clears cursor, slot count, epoch and the pipeline valids; the slot
// table needs no clearing. The receiver cannot stall the result.
module bump_arena_handle_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      req_type,
    input  logic [20:0]                     alloc_size,
    input  logic [16:0]                     align_bytes,
    input  logic [31:0]                     handle_slot,
    input  logic [63:0]                     handle_generation,
    input  logic [1:0]                      handle_arena,
    // result
    output logic                            done,
    output logic [2:0]                      status,
    output logic [20:0]                     region_offset,
    output logic [20:0]                     region_size,
    output logic [7:0]                      new_slot,
    output logic [63:0]                     new_generation,
    output logic [1:0]                      new_arena,
    output logic [20:0]                     cursor_now,
    output logic [8:0]                      live_slots,
    output logic [31:0]                     epoch_now,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import bap_pkg::*;

    // configuration registers
    logic [CAP_BITS-1:0]   capacity_reg;
    logic [1:0]            identity_reg;

    // arena state
    logic [CAP_BITS-1:0]   cursor_reg, cursor_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;

    // input stage
    logic                  vld_reg;
    req_t                  req_reg;
    logic [20:0]           size_reg;
    logic [16:0]           align_reg;
    logic [31:0]           hslot_reg;
    logic [63:0]           hgen_reg;
    logic [1:0]            harena_reg;

    // result stage
    logic                  done_reg;
    status_t               status_reg, status_next;
    logic [20:0]           roff_reg, roff_next;
    logic [20:0]           rsize_reg, rsize_next;
    logic [7:0]            nslot_reg, nslot_next;
    logic [63:0]           ngen_reg, ngen_next;
    logic [1:0]            narena_reg, narena_next;

    logic                  accept;
    logic                  cfg_wr;
    slot_entry_t           entry;
    tbl_wr_t               tbl_wr;

    logic [CAP_BITS-1:0]   cap;
    logic [16:0]           align_m1;
    logic                  align_ok;
    logic [CAP_BITS:0]     aligned;
    logic                  fits;
    logic [EPOCH_BITS-1:0] epoch_inc;
    logic                  hdl_bad;
    logic                  hdl_stale;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;

    // APB register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            identity_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_CAPACITY)
            begin
                capacity_reg <= pwdata[CAP_BITS-1:0];
            end
            else
            begin
                identity_reg <= pwdata[1:0];
            end
        end
    end

    // APB read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_CAPACITY)
        begin
            prdata[CAP_BITS-1:0] = capacity_reg;
        end
        else
        begin
            prdata[1:0] = identity_reg;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_t'(req_type);
            size_reg   <= alloc_size;
            align_reg  <= align_bytes;
            hslot_reg  <= handle_slot;
            hgen_reg   <= handle_generation;
            harena_reg <= handle_arena;
        end
    end

    // slot table, read at the presented slot as the request is taken
    bap_slot_tbl u_slot_tbl
    (
        .clk     (clk),
        .rd_addr (handle_slot[SLOT_BITS-1:0]),
        .wr      (tbl_wr),
        .rd_data (entry)
    );

    // allocation arithmetic
    assign cap      = (capacity_reg > CAP_LIMIT) ? CAP_LIMIT : capacity_reg;
    assign align_m1 = align_reg - 17'd1;
    assign align_ok = (align_reg != '0) && ((align_reg & align_m1) == '0)
                      && (align_reg <= 17'(MAX_ALIGN));
    assign aligned  = ({1'b0, cursor_reg} + (CAP_BITS+1)'(align_m1))
                      & ~((CAP_BITS+1)'(align_m1));
    assign fits     = (size_reg <= cap) && (aligned <= {1'b0, cap})
                      && ((CAP_BITS+1)'(size_reg) <= ({1'b0, cap} - aligned))
                      && (count_reg < SLOTS_FULL);
    assign epoch_inc = (epoch_reg + 32'd1 == '0) ? 32'd1 : epoch_reg + 32'd1;

    // handle checks against the table entry
    assign hdl_bad   = (harena_reg != identity_reg)
                       || ((req_reg == REQ_RESOLVE) && (hgen_reg == '0))
                       || (hslot_reg >= 32'(count_reg));
    assign hdl_stale = !entry.active || (hgen_reg[63:32] != entry.epoch)
                       || (hgen_reg[31:0] != hslot_reg + 32'd1);

    // request execution
    always_comb
    begin
        cursor_next = cursor_reg;
        count_next  = count_reg;
        epoch_next  = epoch_reg;
        status_next = ST_OK;
        roff_next   = '0;
        rsize_next  = '0;
        nslot_next  = '0;
        ngen_next   = '0;
        narena_next = '0;
        tbl_wr      = '0;
        unique case (req_reg)
            REQ_ALLOC:
            begin
                tbl_wr.addr = count_reg[SLOT_BITS-1:0];
                if ((size_reg == '0) || !align_ok)
                begin
                    status_next = ST_BAD_ARG;
                end
                else if (!fits)
                begin
                    status_next = ST_NO_MEM;
                end
                else
                begin
                    tbl_wr.en          = vld_reg;
                    tbl_wr.data.offset = aligned[OFFSET_BITS-1:0];
                    tbl_wr.data.size   = size_reg;
                    tbl_wr.data.epoch  = epoch_reg;
                    tbl_wr.data.active = 1'b1;
                    cursor_next = aligned[CAP_BITS-1:0] + size_reg;
                    count_next  = count_reg + CNT_BITS'(1);
                    roff_next   = {1'b0, aligned[OFFSET_BITS-1:0]};
                    rsize_next  = size_reg;
                    nslot_next  = count_reg[SLOT_BITS-1:0];
                    ngen_next   = {epoch_reg, 32'(count_reg) + 32'd1};
                    narena_next = identity_reg;
                end
            end
            REQ_RESOLVE:
            begin
                if (hdl_bad)
                begin
                    status_next = ST_BAD_HANDLE;
                end
                else if (hdl_stale)
                begin
                    status_next = ST_STALE;
                end
                else
                begin
                    roff_next  = {1'b0, entry.offset};
                    rsize_next = entry.size;
                end
            end
            REQ_ABANDON:
            begin
                tbl_wr.addr = hslot_reg[SLOT_BITS-1:0];
                tbl_wr.data = entry;
                tbl_wr.data.active = 1'b0;
                if (hdl_bad)
                begin
                    status_next = ST_BAD_HANDLE;
                end
                else if (hdl_stale)
                begin
                    status_next = ST_STALE;
                end
                else
                begin
                    tbl_wr.en = vld_reg;
                end
            end
            REQ_RESET:
            begin
                cursor_next = '0;
                count_next  = '0;
                epoch_next  = epoch_inc;
            end
            default:
            begin
                status_next = ST_BAD_ARG;
            end
        endcase
    end

    // arena state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            count_reg  <= '0;
            epoch_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg;
            if (vld_reg)
            begin
                cursor_reg <= cursor_next;
                count_reg  <= count_next;
                epoch_reg  <= epoch_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (vld_reg)
        begin
            status_reg <= status_next;
            roff_reg   <= roff_next;
            rsize_reg  <= rsize_next;
            nslot_reg  <= nslot_next;
            ngen_reg   <= ngen_next;
            narena_reg <= narena_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign region_offset  = roff_reg;
    assign region_size    = rsize_reg;
    assign new_slot       = nslot_reg;
    assign new_generation = ngen_reg;
    assign new_arena      = narena_reg;
    assign cursor_now     = cursor_reg;
    assign live_slots     = count_reg;
    assign epoch_now      = epoch_reg;

endmodule
